FILE: src/pcbf_pkg.sv
// pcbf_pkg: shared widths, constants, types and helpers for the corner bezier fitter
// used by pcbf_front, pcbf_queue, pcbf_back and the top level
// no dependencies
`default_nettype none
package pcbf_pkg;
	// coordinate and fixed point widths
	localparam int CB  = 12;
	localparam int FB  = 8;
	localparam int XW  = 12;
	localparam int OW  = 20;
	localparam int PW  = CB + FB;
	localparam int DFW = CB + 1;
	localparam int AW  = 2 * CB + 3;
	localparam int NW  = CB + 3;
	localparam int N7W = CB + 7;
	localparam int DW  = (CB + 6 > 24) ? CB + 6 : 24;
	localparam int CW  = CB + 32;
	localparam int TW  = 32;
	localparam int DIV_STEPS = TW / 2;
	localparam int DCW = $clog2(DIV_STEPS);

	// clamp at t = 0.7761425
	localparam logic [DW-1:0] CLAMP_NUM = DW'(7761425);
	localparam logic [DW-1:0] CLAMP_DEN = DW'(10000000);
	localparam logic signed [CW-1:0] K_N7 = CW'(10000000);
	localparam logic signed [CW-1:0] K_A  = CW'(46568550);
	localparam logic [CB+TW:0] RND = (CB+TW+1)'(1) << (TW - 1 - FB);

	// stream widths
	localparam int IN_TDATA_W  = ((2 * XW + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((8 * OW + 7) / 8) * 8;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
	} vtx_t;

	typedef enum logic {JOB_LINE, JOB_CORNER} job_kind_t;

	typedef struct packed {
		job_kind_t     kind;
		logic          last;
		vtx_t          pi;
		vtx_t          pj;
		vtx_t          pv;
		logic [PW-1:0] p0x;
		logic [PW-1:0] p0y;
		logic [PW-1:0] p3x;
		logic [PW-1:0] p3y;
	} job_t;

	typedef struct packed {
		logic [OW-1:0] sx;
		logic [OW-1:0] sy;
		logic [OW-1:0] ax;
		logic [OW-1:0] ay;
		logic [OW-1:0] bx;
		logic [OW-1:0] by;
		logic [OW-1:0] ex;
		logic [OW-1:0] ey;
		logic          last;
	} curve_t;

	// integer coordinate to fixed point
	function automatic logic [PW-1:0] fix(input logic [CB-1:0] c);
		return {c, {FB{1'b0}}};
	endfunction

	// exact midpoint of two integer coordinates in fixed point
	function automatic logic [PW-1:0] mid(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return PW'({s, {(FB-1){1'b0}}});
	endfunction

	// straight curve a->b, both control points at the midpoint
	function automatic curve_t line(input logic [PW-1:0] ax, input logic [PW-1:0] ay,
			input logic [PW-1:0] bx, input logic [PW-1:0] by, input logic last);
		curve_t c;
		logic [PW:0] mx;
		logic [PW:0] my;
		mx = ({1'b0, ax} + {1'b0, bx}) >> 1;
		my = ({1'b0, ay} + {1'b0, by}) >> 1;
		c.sx = OW'(ax);
		c.sy = OW'(ay);
		c.ax = OW'(mx);
		c.ay = OW'(my);
		c.bx = OW'(mx);
		c.by = OW'(my);
		c.ex = OW'(bx);
		c.ey = OW'(by);
		c.last = last;
		return c;
	endfunction
endpackage
`default_nettype wire

FILE: src/pcbf_front.sv
// pcbf_front: accepts vertices, keeps the vertex window and builds corner jobs
// depends on pcbf_pkg
`default_nettype none
module pcbf_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [pcbf_pkg::XW-1:0]   in_x,
	input  wire logic [pcbf_pkg::XW-1:0]   in_y,
	input  wire logic                      in_last,
	input  wire logic                      q_full,
	output logic                           push,
	output pcbf_pkg::job_t                 job
);
	logic [1:0]      seen_q;
	pcbf_pkg::vtx_t  first_q;
	pcbf_pkg::vtx_t  older_q;
	pcbf_pkg::vtx_t  newer_q;
	pcbf_pkg::vtx_t  v;
	logic            acc;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;

	// job for the corner at the middle vertex, or the two vertex line
	always_comb begin
		v.x = pcbf_pkg::CB'(in_x);
		v.y = pcbf_pkg::CB'(in_y);
		push = acc && (seen_q[1] || (seen_q == 2'd1 && in_last));
		job.kind = (seen_q == 2'd1) ? pcbf_pkg::JOB_LINE : pcbf_pkg::JOB_CORNER;
		job.last = in_last;
		job.pi = older_q;
		job.pj = newer_q;
		job.pv = v;
		if (seen_q == 2'd3) begin
			job.p0x = pcbf_pkg::mid(older_q.x, newer_q.x);
			job.p0y = pcbf_pkg::mid(older_q.y, newer_q.y);
		end else begin
			job.p0x = pcbf_pkg::fix(first_q.x);
			job.p0y = pcbf_pkg::fix(first_q.y);
		end
		if (in_last) begin
			job.p3x = pcbf_pkg::fix(v.x);
			job.p3y = pcbf_pkg::fix(v.y);
		end else begin
			job.p3x = pcbf_pkg::mid(v.x, newer_q.x);
			job.p3y = pcbf_pkg::mid(v.y, newer_q.y);
		end
	end

	// vertex window and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 2'd0;
			first_q <= '0;
			older_q <= '0;
			newer_q <= '0;
		end else if (acc) begin
			case (seen_q)
				2'd0: begin
					first_q <= v;
					newer_q <= v;
					seen_q  <= in_last ? 2'd0 : 2'd1;
				end
				2'd1: begin
					if (in_last) begin
						seen_q <= 2'd0;
					end else begin
						older_q <= newer_q;
						newer_q <= v;
						seen_q  <= 2'd2;
					end
				end
				default: begin
					older_q <= newer_q;
					newer_q <= v;
					seen_q  <= in_last ? 2'd0 : 2'd3;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/pcbf_queue.sv
// pcbf_queue: two entry job queue between front and back
// depends on pcbf_pkg
`default_nettype none
module pcbf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pcbf_pkg::job_t din,
	output logic                full,
	input  wire logic           pop,
	output pcbf_pkg::job_t      dout,
	output logic                not_empty
);
	pcbf_pkg::job_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;

	assign full = count_q[1];
	assign not_empty = count_q != 2'd0;
	assign dout = mem_q[rptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

FILE: src/pcbf_back.sv
// pcbf_back: corner sequencer with area, clamp compare, radix-4 divider and offsets
// depends on pcbf_pkg; takes jobs from pcbf_queue, drives the output register
`default_nettype none
module pcbf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             not_empty,
	input  wire pcbf_pkg::job_t   jin,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pcbf_pkg::curve_t      out_curve
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_AREA, ST_CLS, ST_CMP, ST_SEL, ST_DIV, ST_OFF, ST_EMIT_A, ST_EMIT_B
	} state_t;

	state_t                               state_q;
	pcbf_pkg::job_t                       job_q;
	logic signed [2*pcbf_pkg::DFW-1:0]    prod1_q;
	logic signed [2*pcbf_pkg::DFW-1:0]    prod2_q;
	logic [pcbf_pkg::CB:0]                den_q;
	logic [pcbf_pkg::NW-1:0]              a_q;
	logic signed [pcbf_pkg::N7W-1:0]      n7_q;
	logic                                 sharp_q;
	logic signed [pcbf_pkg::CW-1:0]       lhs_q;
	logic signed [pcbf_pkg::CW-1:0]       rhs_q;
	logic [pcbf_pkg::DW-1:0]              rem_q;
	logic [pcbf_pkg::DW-1:0]              dd_q;
	logic [pcbf_pkg::TW-1:0]              t_q;
	logic [pcbf_pkg::DCW-1:0]             cnt_q;
	logic [2:0]                           idx_q;
	logic [pcbf_pkg::CB+pcbf_pkg::TW-1:0] mprod_q;
	logic [pcbf_pkg::OW-1:0]              ctrl_q [4];
	logic                                 out_valid_q;
	pcbf_pkg::curve_t                     out_q;

	logic signed [pcbf_pkg::DFW-1:0]      dx;
	logic signed [pcbf_pkg::DFW-1:0]      dy;
	logic signed [pcbf_pkg::DFW-1:0]      ex;
	logic signed [pcbf_pkg::DFW-1:0]      ey;
	logic signed [pcbf_pkg::AW-1:0]       area;
	logic [pcbf_pkg::AW-1:0]              afull;
	logic                                 sharp;
	logic [pcbf_pkg::NW+2:0]              a7;
	logic [pcbf_pkg::DW:0]                st1;
	logic [pcbf_pkg::DW:0]                st2;
	logic signed [pcbf_pkg::DFW-1:0]      doff;
	logic [pcbf_pkg::PW-1:0]              base;
	logic [pcbf_pkg::CB+pcbf_pkg::TW:0]   rsum;
	logic [pcbf_pkg::PW:0]                rr;
	logic signed [pcbf_pkg::PW+1:0]       csum;
	logic                                 emit_go;
	pcbf_pkg::curve_t                     nxt;

	// magnitude of a coordinate difference
	function automatic logic [pcbf_pkg::CB-1:0] absd(input logic signed [pcbf_pkg::DFW-1:0] d);
		return d[pcbf_pkg::DFW-1] ? pcbf_pkg::CB'(-d) : pcbf_pkg::CB'(d);
	endfunction

	// one restoring divider step: quotient bit over new remainder
	function automatic logic [pcbf_pkg::DW:0] div_step(input logic [pcbf_pkg::DW-1:0] r,
			input logic [pcbf_pkg::DW-1:0] d);
		logic [pcbf_pkg::DW:0] r2;
		r2 = {r, 1'b0};
		if (r2 >= {1'b0, d}) begin
			r2 = r2 - {1'b0, d};
			return {1'b1, r2[pcbf_pkg::DW-1:0]};
		end
		return {1'b0, r2[pcbf_pkg::DW-1:0]};
	endfunction

	assign pop = (state_q == ST_IDLE) && not_empty;
	assign out_valid = out_valid_q;
	assign out_curve = out_q;
	assign emit_go = (state_q == ST_EMIT_A || state_q == ST_EMIT_B)
		&& (!out_valid_q || out_ready);

	// corner geometry and arithmetic helpers
	always_comb begin
		dx = $signed({1'b0, job_q.pv.x}) - $signed({1'b0, job_q.pi.x});
		dy = $signed({1'b0, job_q.pv.y}) - $signed({1'b0, job_q.pi.y});
		ex = $signed({1'b0, job_q.pj.x}) - $signed({1'b0, job_q.pi.x});
		ey = $signed({1'b0, job_q.pj.y}) - $signed({1'b0, job_q.pi.y});
		area = pcbf_pkg::AW'(prod1_q) - pcbf_pkg::AW'(prod2_q);
		afull = area[pcbf_pkg::AW-1] ? pcbf_pkg::AW'(-area) : pcbf_pkg::AW'(area);
		sharp = (den_q == '0) || (afull >= pcbf_pkg::AW'({den_q, 2'b00}));
		a7 = {afull[pcbf_pkg::NW-1:0], 3'b000} - (pcbf_pkg::NW+3)'(afull[pcbf_pkg::NW-1:0]);
		st1 = div_step(rem_q, dd_q);
		st2 = div_step(st1[pcbf_pkg::DW-1:0], dd_q);
		case (idx_q[2:1])
			2'd0: begin
				doff = ex;
				base = pcbf_pkg::fix(job_q.pi.x);
			end
			2'd1: begin
				doff = ey;
				base = pcbf_pkg::fix(job_q.pi.y);
			end
			2'd2: begin
				doff = $signed({1'b0, job_q.pj.x}) - $signed({1'b0, job_q.pv.x});
				base = pcbf_pkg::fix(job_q.pv.x);
			end
			default: begin
				doff = $signed({1'b0, job_q.pj.y}) - $signed({1'b0, job_q.pv.y});
				base = pcbf_pkg::fix(job_q.pv.y);
			end
		endcase
		rsum = {1'b0, mprod_q} + pcbf_pkg::RND;
		rr = rsum[pcbf_pkg::CB+pcbf_pkg::TW:pcbf_pkg::TW-pcbf_pkg::FB];
		if (doff[pcbf_pkg::DFW-1]) begin
			csum = $signed({2'b00, base}) - $signed({1'b0, rr});
		end else begin
			csum = $signed({2'b00, base}) + $signed({1'b0, rr});
		end
	end

	// result selection
	always_comb begin
		if (job_q.kind == pcbf_pkg::JOB_LINE) begin
			nxt = pcbf_pkg::line(job_q.p0x, job_q.p0y, job_q.p3x, job_q.p3y, job_q.last);
		end else if (sharp_q && state_q == ST_EMIT_A) begin
			nxt = pcbf_pkg::line(job_q.p0x, job_q.p0y, pcbf_pkg::fix(job_q.pj.x),
				pcbf_pkg::fix(job_q.pj.y), 1'b0);
		end else if (sharp_q) begin
			nxt = pcbf_pkg::line(pcbf_pkg::fix(job_q.pj.x), pcbf_pkg::fix(job_q.pj.y),
				job_q.p3x, job_q.p3y, job_q.last);
		end else begin
			nxt.sx = pcbf_pkg::OW'(job_q.p0x);
			nxt.sy = pcbf_pkg::OW'(job_q.p0y);
			nxt.ax = ctrl_q[0];
			nxt.ay = ctrl_q[1];
			nxt.bx = ctrl_q[2];
			nxt.by = ctrl_q[3];
			nxt.ex = pcbf_pkg::OW'(job_q.p3x);
			nxt.ey = pcbf_pkg::OW'(job_q.p3y);
			nxt.last = job_q.last;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= jin;
		end
		if (emit_go) begin
			out_q <= nxt;
		end
		case (state_q)
			ST_AREA: begin
				prod1_q <= ex * dy;
				prod2_q <= dx * ey;
				den_q <= {1'b0, absd(dx)} + {1'b0, absd(dy)};
			end
			ST_CLS: begin
				sharp_q <= sharp;
				a_q <= afull[pcbf_pkg::NW-1:0];
				n7_q <= $signed(pcbf_pkg::N7W'(a7) - pcbf_pkg::N7W'({den_q, 2'b00}));
			end
			ST_CMP: begin
				lhs_q <= pcbf_pkg::CW'(n7_q) * pcbf_pkg::K_N7;
				rhs_q <= $signed(pcbf_pkg::CW'(a_q)) * pcbf_pkg::K_A;
			end
			ST_SEL: begin
				if (lhs_q < rhs_q) begin
					rem_q <= pcbf_pkg::CLAMP_NUM;
					dd_q  <= pcbf_pkg::CLAMP_DEN;
				end else begin
					rem_q <= pcbf_pkg::DW'($unsigned(n7_q));
					dd_q  <= pcbf_pkg::DW'({a_q, 2'b00}) + pcbf_pkg::DW'({a_q, 1'b0});
				end
				t_q <= '0;
			end
			ST_DIV: begin
				rem_q <= st2[pcbf_pkg::DW-1:0];
				t_q <= {t_q[pcbf_pkg::TW-3:0], st1[pcbf_pkg::DW], st2[pcbf_pkg::DW]};
			end
			ST_OFF: begin
				if (!idx_q[0]) begin
					mprod_q <= pcbf_pkg::CB'(absd(doff)) * t_q;
				end else begin
					ctrl_q[idx_q[2:1]] <= pcbf_pkg::OW'(csum);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_AREA;
					end
				end
				ST_AREA: begin
					state_q <= (job_q.kind == pcbf_pkg::JOB_LINE) ? ST_EMIT_A : ST_CLS;
				end
				ST_CLS: begin
					state_q <= sharp ? ST_EMIT_A : ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == pcbf_pkg::DCW'(pcbf_pkg::DIV_STEPS - 1)) begin
						idx_q <= '0;
						state_q <= ST_OFF;
					end
				end
				ST_OFF: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 3'd7) begin
						state_q <= ST_EMIT_A;
					end
				end
				ST_EMIT_A: begin
					if (emit_go) begin
						state_q <= (job_q.kind == pcbf_pkg::JOB_CORNER && sharp_q)
							? ST_EMIT_B : ST_IDLE;
					end
				end
				ST_EMIT_B: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider keeps a nonzero divisor and a remainder below it
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dd_q != '0)
		else $error("divider entered with zero divisor");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < dd_q)
		else $error("divider remainder not below divisor");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_AREA)
		else $error("job taken while sequencer busy");
	a_emit_b: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_B |-> sharp_q && job_q.kind == pcbf_pkg::JOB_CORNER)
		else $error("second result on a non sharp job");
endmodule
`default_nettype wire

FILE: src/polygon_corner_bezier_fitter_unit.sv
// latency: a two vertex path passes the back sequencer through ST_AREA and ST_EMIT_A,
// a sharp corner through ST_AREA, ST_CLS, ST_EMIT_A and ST_EMIT_B, a smoothed corner
// through ST_AREA, ST_CLS, ST_CMP, ST_SEL, the radix-4 divider, the offsets, ST_EMIT_A
// throughput: one job at a time in the back sequencer, whose emit states wait while the
// output is held; a two entry job queue lets vertices arrive meanwhile
// reset: arst_n clears the vertex window, the queue and the output valid flag at once
`default_nettype none
module polygon_corner_bezier_fitter_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// vertex_x [11:0], vertex_y [23:12]
	input  wire logic [pcbf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire logic                                s_axis_tlast,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y, 20 bits each
	output logic [pcbf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	output logic                                     m_axis_tlast
);
	logic              push;
	logic              pop;
	logic              q_full;
	logic              not_empty;
	pcbf_pkg::job_t    job_in;
	pcbf_pkg::job_t    job_out;
	pcbf_pkg::curve_t  curve;

	// vertex front end
	pcbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_x     (s_axis_tdata[pcbf_pkg::XW-1:0]),
		.in_y     (s_axis_tdata[2*pcbf_pkg::XW-1:pcbf_pkg::XW]),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.push     (push),
		.job      (job_in)
	);

	// job queue
	pcbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (job_in),
		.full      (q_full),
		.pop       (pop),
		.dout      (job_out),
		.not_empty (not_empty)
	);

	// corner back end
	pcbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.jin       (job_out),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_curve (curve)
	);

	// result packing
	assign m_axis_tdata = pcbf_pkg::OUT_TDATA_W'({curve.ey, curve.ex, curve.by, curve.bx,
		curve.ay, curve.ax, curve.sy, curve.sx});
	assign m_axis_tlast = curve.last;
endmodule
`default_nettype wire

FILE: verif/polygon_corner_bezier_fitter_unit_tb.sv
// testbench for polygon_corner_bezier_fitter_unit: streams polygon paths in and checks curves
// predicts every curve in a small scoreboard class; depends on pcbf_pkg and the top level
`default_nettype none
module polygon_corner_bezier_fitter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLIP = 12;
	localparam int FRAC = 8;
	localparam longint CYCLE_LIMIT = 2000000;

	// one expected curve
	typedef struct {
		logic [19:0] pt[8];
		logic        last;
	} bez_t;

	class curve_board;
		bez_t         pending[$];
		int           errors;
		longint       ox, oy, nx, ny, fx, fy;
		int           seen;

		function new();
			errors = 0;
			seen = 0;
			ox = 0; oy = 0; nx = 0; ny = 0; fx = 0; fy = 0;
		endfunction

		function void push(longint v[8], bit last);
			bez_t b;
			for (int n = 0; n < 8; n++) b.pt[n] = v[n][19:0];
			b.last = last;
			pending.insert(pending.size(), b);
		endfunction

		function void push_line(longint ax, longint ay, longint bx, longint by, bit last);
			longint v[8];
			v = '{ax, ay, (ax + bx) / 2, (ay + by) / 2, (ax + bx) / 2, (ay + by) / 2, bx, by};
			push(v, last);
		endfunction

		function longint offset_of(longint d, longint unsigned t32);
			longint unsigned m, r;
			m = longint'(d < 0 ? -d : d) * t32;
			r = (m + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
			return d < 0 ? -longint'(r) : longint'(r);
		endfunction

		// note an accepted vertex request and predict its curves
		function void note_vertex(logic [11:0] vx, logic [11:0] vy, bit last);
			longint x, y, p0x, p0y, p3x, p3y, dx, dy, den, a, n7;
			longint unsigned num, dd, q, r;
			longint v[8];
			x = vx; y = vy;
			if (seen == 0) begin
				fx = x; fy = y; nx = x; ny = y;
				seen = last ? 0 : 1;
				return;
			end
			if (seen == 1) begin
				if (last) begin
					push_line(fx << FRAC, fy << FRAC, x << FRAC, y << FRAC, 1);
					seen = 0;
					return;
				end
				ox = nx; oy = ny; nx = x; ny = y; seen = 2;
				return;
			end
			if (seen == 2) begin
				p0x = fx << FRAC; p0y = fy << FRAC;
			end else begin
				p0x = (ox + nx) << (FRAC - 1); p0y = (oy + ny) << (FRAC - 1);
			end
			if (last) begin
				p3x = x << FRAC; p3y = y << FRAC;
			end else begin
				p3x = (x + nx) << (FRAC - 1); p3y = (y + ny) << (FRAC - 1);
			end
			dx = x - ox; dy = y - oy;
			den = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
			a = (nx - ox) * dy - dx * (ny - oy);
			if (a < 0) a = -a;
			if (den == 0 || a >= 4 * den) begin
				push_line(p0x, p0y, nx << FRAC, ny << FRAC, 0);
				push_line(nx << FRAC, ny << FRAC, p3x, p3y, last);
			end else begin
				n7 = 7 * a - 4 * den;
				if (n7 * 10000000 < 6 * a * 7761425) begin
					num = 7761425; dd = 10000000;
				end else begin
					num = n7; dd = 6 * a;
				end
				q = 0; r = num;
				for (int b = 0; b < 32; b++) begin
					r = r << 1; q = q << 1;
					if (r >= dd) begin
						r -= dd; q |= 1;
					end
				end
				v = '{p0x, p0y,
					(ox << FRAC) + offset_of(nx - ox, q),
					(oy << FRAC) + offset_of(ny - oy, q),
					(x << FRAC) + offset_of(nx - x, q),
					(y << FRAC) + offset_of(ny - y, q),
					p3x, p3y};
				push(v, last);
			end
			ox = nx; oy = ny; nx = x; ny = y;
			seen = last ? 0 : 3;
		endfunction

		// compare one accepted curve with the oldest prediction
		function void check_curve(logic [159:0] data, logic last);
			bez_t b;
			string names[8];
			names = '{"start_x", "start_y", "ctrl1_x", "ctrl1_y",
				"ctrl2_x", "ctrl2_y", "end_x", "end_y"};
			if (pending.size() == 0) begin
				$error("unexpected curve %h", data);
				errors++;
				return;
			end
			b = pending.pop_front();
			for (int n = 0; n < 8; n++)
				if (data[n*20 +: 20] !== b.pt[n]) begin
					$error("%s: expected %0d, got %0d", names[n], b.pt[n], data[n*20 +: 20]);
					errors++;
				end
			if (last !== b.last) begin
				$error("last_curve: expected %0d, got %0d", b.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	wire logic s_axis_tready;
	logic [pcbf_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 0;
	wire logic m_axis_tvalid;
	logic m_axis_tready = 0;
	wire logic [pcbf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	wire logic m_axis_tlast;

	curve_board board = new();
	int sender_idle = 0;
	int receiver_idle = 0;
	bit hold_off = 0;
	longint cycles = 0;

	polygon_corner_bezier_fitter_unit dut (.*);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("polygon_corner_bezier_fitter_unit_tb: done, errors");
			$finish;
		end
	end

	// receiver with random stalls and the long hold-off
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_curve(m_axis_tdata[159:0], m_axis_tlast);
		m_axis_tready <= !hold_off && ($urandom_range(99) >= receiver_idle);
	end

	// send one vertex request, with random idle gaps first
	task automatic send_vertex(logic [11:0] x, logic [11:0] y, bit last);
		while ($urandom_range(99) < sender_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= pcbf_pkg::IN_TDATA_W'({y, x});
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		board.note_vertex(x[CLIP-1:0], y[CLIP-1:0], last);
	endtask

	// a well-formed path of n vertices, mostly near one another so smooth corners occur
	task automatic send_path(int n, int spread);
		int cx, cy;
		cx = $urandom_range(4095); cy = $urandom_range(4095);
		for (int k = 0; k < n; k++) begin
			cx = (cx + $urandom_range(2 * spread) - spread) & 12'hfff;
			cy = (cy + $urandom_range(2 * spread) - spread) & 12'hfff;
			send_vertex(12'(cx), 12'(cy), k == n - 1);
		end
	endtask

	// stop offering and wait for every expected curve
	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	int sent;

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single vertex, two vertex line, extremes, equal outer points,
		// flat and sharp corners
		send_vertex(12'hfff, 12'hfff, 1);
		send_vertex(0, 0, 0);
		send_vertex(12'hfff, 12'hfff, 1);
		send_vertex(0, 12'hfff, 0);
		send_vertex(12'hfff, 0, 0);
		send_vertex(0, 12'hfff, 0);
		send_vertex(10, 10, 0);
		send_vertex(20, 20, 0);
		send_vertex(30, 30, 0);
		send_vertex(31, 30, 0);
		send_vertex(40, 33, 0);
		send_vertex(41, 35, 0);
		send_vertex(12'hfff, 0, 0);
		send_vertex(0, 0, 1);
		send_vertex(100, 100, 0);
		send_vertex(110, 101, 0);
		send_vertex(120, 104, 1);
		drain();

		// receiver holds off while the sender keeps offering
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			send_path(20, 40);
		join
		drain();

		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			sender_idle = phase == 0 ? 23 : phase == 1 ? 72 : 0;
			receiver_idle = phase == 0 ? 72 : phase == 1 ? 23 : 0;
			for (int n = 0; n < 310; ) begin
				int len;
				case ($urandom_range(9))
					0: begin
						len = 2;
						send_vertex(12'($urandom), 12'($urandom), 1);
						send_vertex(12'($urandom), 12'($urandom), 1'($urandom_range(1)));
					end
					1: begin
						len = $urandom_range(8, 3);
						for (int k = 0; k < len; k++)
							send_vertex(12'($urandom), 12'($urandom), k == len - 1);
					end
					default: begin
						len = $urandom_range(12, 3);
						send_path(len, $urandom_range(3) == 0 ? 2000 : 8);
					end
				endcase
				n += len;
			end
			// pause until everything is out
			drain();
		end
		send_vertex(0, 0, 1);
		drain();

		if (board.errors == 0)
			$display("polygon_corner_bezier_fitter_unit_tb: done, clean");
		else
			$display("polygon_corner_bezier_fitter_unit_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
